@@ rtl/core/chol_pkg.sv @@
// Shared types and constants of the Cholesky linear solver.
// No dependencies; imported by chol_sqrt, chol_div and cholesky_linear_solver.
`default_nettype none
package chol_pkg;

	localparam int N_MAX  = 16;
	localparam int IDX_W  = 4;
	localparam int ADDR_W = 8;
	localparam int WORD_W = 32;
	localparam int ACC_W  = 64;

	typedef enum logic [1:0] {
		REQ_WRITE_MATRIX = 2'd0,
		REQ_WRITE_RHS    = 2'd1,
		REQ_SOLVE        = 2'd2,
		REQ_NONE         = 2'd3
	} req_t;

	typedef enum logic {
		CFG_SIZE_IN_USE = 1'b0,
		CFG_MIN_PIVOT   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_FACT,
		PH_FWD,
		PH_BWD,
		PH_EMIT
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT_RD,
		ST_INIT_CAP,
		ST_A_RD,
		ST_B_RD,
		ST_MUL,
		ST_ACC,
		ST_FIN,
		ST_PIV_RD,
		ST_PIV_CAP,
		ST_SQRT,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT,
		ST_FAIL
	} state_t;

	localparam logic            STATUS_OK   = 1'b0;
	localparam logic            STATUS_FAIL = 1'b1;
	localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;

	// widen a Q16.16 word to Q32.32
	function automatic logic [ACC_W-1:0] to_q32(input logic [WORD_W-1:0] w);
		to_q32 = {{16{w[WORD_W-1]}}, w, 16'h0000};
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/chol_sqrt.sv @@
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
// Uses chol_pkg.
`default_nettype none
module chol_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [chol_pkg::ACC_W-1:0]   radicand,
	output logic                              done,
	output logic [chol_pkg::WORD_W-1:0]       root
);
	import chol_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [ACC_W-1:0]  rad_q;
	logic [33:0]       rem_q;
	logic [WORD_W-1:0] root_q;
	logic [35:0]       rem_t;
	logic [35:0]       trial;
	logic              fits;

	assign rem_t = {rem_q, rad_q[ACC_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = rem_t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[ACC_W-3:0], 2'b00};
			rem_q  <= fits ? 34'(rem_t - trial) : rem_t[33:0];
			root_q <= {root_q[WORD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

@@ rtl/core/chol_div.sv @@
// Iterative signed 64 by 32 division, truncated toward zero, saturated to 32 bits.
// Uses chol_pkg; one quotient bit per cycle.
`default_nettype none
module chol_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [chol_pkg::ACC_W-1:0]   dividend,
	input  wire logic [chol_pkg::WORD_W-1:0]  divisor,
	output logic                              done,
	output logic [chol_pkg::WORD_W-1:0]       quotient
);
	import chol_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [ACC_W-1:0]  num_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dmag_q;
	logic              neg_q;
	logic [WORD_W:0]   rem_t;
	logic              fits;
	logic              big;

	assign rem_t = {rem_q, num_q[ACC_W-1]};
	assign fits  = rem_t >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend[ACC_W-1] ? (~dividend + 64'd1) : dividend;
			dmag_q <= divisor[WORD_W-1] ? (~divisor + 32'd1) : divisor;
			neg_q  <= dividend[ACC_W-1] ^ divisor[WORD_W-1];
			rem_q  <= '0;
		end else if (run_q) begin
			num_q <= {num_q[ACC_W-2:0], fits};
			rem_q <= fits ? WORD_W'(rem_t - {1'b0, dmag_q}) : rem_t[WORD_W-1:0];
		end
	end

	// magnitude above 2^31 saturates negative results, at or above it positive ones
	assign big = (|num_q[ACC_W-1:WORD_W]) || (num_q[WORD_W-1] && (|num_q[WORD_W-2:0]));

	always_comb begin
		if (neg_q)
			quotient = big ? WORD_MIN : (~num_q[WORD_W-1:0] + 32'd1);
		else
			quotient = (|num_q[ACC_W-1:WORD_W-1]) ? WORD_MAX : num_q[WORD_W-1:0];
	end

	assign done = done_q;

endmodule
`default_nettype wire

@@ rtl/core/cholesky_linear_solver.sv @@
// Cholesky solver for A*x = b in signed Q16.16: load, factor in place, substitute.
// Uses chol_pkg, chol_sqrt and chol_div; holds matrix, rhs and solution memories.
//
// Use: while busy is low, pulse start with req_type, row, col and data_word.
// A matrix or rhs write gives no result. A solve request raises busy,
// factors the first n rows (n from size_in_use, 0 read as 1, above 16 read
// as 16), then runs forward and back substitution and emits x[0..n-1] on
// result_valid, last set on x[n-1]. A failing pivot gives a single word
// with status 1 and last 1 instead.
// Each inner product term steps through two operand reads (both on the single
// matrix port while factoring, the second from the solution memory while
// substituting), multiply and accumulate, after a setup read and capture of
// the start value; each diagonal entry then waits on the square root and every
// other entry on a pivot read and a division. The shared divider and the one
// matrix read port set the time that a solve takes.
// Write requests are taken back to back, one per cycle.
// Configuration: cfg_index 0 size_in_use, 1 min_pivot; cfg_ready is always
// high; writes must be made only while busy is low, which the block does not enforce.
// Reset clears control and sets size_in_use to 16 and min_pivot to 0; the
// memories stay undefined until written. Results cannot be held off.
`default_nettype none
module cholesky_linear_solver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [3:0]  row,
	input  wire logic [3:0]  col,
	input  wire logic [31:0] data_word,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [30:0] cfg_data,
	output logic             result_valid,
	output logic [3:0]       solution_index,
	output logic [31:0]      solution_value,
	output logic             status,
	output logic             last
);
	import chol_pkg::*;

	state_t            state_q, state_d;
	phase_t            phase_q, nxt_phase;
	logic [IDX_W-1:0]  i_q, j_q, k_q, nxt_i, nxt_j;
	logic [IDX_W:0]    n_q;
	logic [4:0]        size_q;
	logic [30:0]       min_pivot_q;
	logic [ACC_W-1:0]  acc_q;
	logic [WORD_W-1:0] a_q;
	logic [ACC_W-1:0]  prod_s2;

	logic [WORD_W-1:0] mat_mem [N_MAX*N_MAX];
	logic [WORD_W-1:0] vec_mem [N_MAX];
	logic [WORD_W-1:0] x_mem   [N_MAX];
	logic [WORD_W-1:0] m_rdata_q, v_rdata_q, x_rdata_q;
	logic [ADDR_W-1:0] m_raddr, m_waddr;
	logic [IDX_W-1:0]  v_raddr, x_raddr, x_waddr;
	logic              m_we, v_we, x_we;
	logic [WORD_W-1:0] m_wdata, x_wdata;

	logic              accept, adv, sqrt_start, div_start, sqrt_done, div_done;
	logic [WORD_W-1:0] sqrt_root, div_quot, sqrt_sat;
	logic [IDX_W:0]    start5, end5, n_init;
	logic              last_i;
	logic [ACC_W:0]    diff;
	logic [ACC_W-1:0]  acc_sub, init_val;
	logic [WORD_W-1:0] b_val;
	logic              not_pd;
	logic              emit_q, fail_q;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// order of the solve: zero reads as one, above N_MAX clamps
	always_comb begin
		if (size_q == 5'd0)
			n_init = (IDX_W+1)'(1);
		else if (size_q > 5'(N_MAX))
			n_init = (IDX_W+1)'(N_MAX);
		else
			n_init = size_q;
	end

	assign last_i = ({1'b0, i_q} == (n_q - (IDX_W+1)'(1)));

	always_comb begin
		case (phase_q)
			PH_FACT: begin
				start5 = '0;
				end5   = {1'b0, j_q};
			end
			PH_FWD: begin
				start5 = '0;
				end5   = {1'b0, i_q};
			end
			PH_BWD: begin
				start5 = {1'b0, i_q} + (IDX_W+1)'(1);
				end5   = n_q;
			end
			default: begin
				start5 = '0;
				end5   = '0;
			end
		endcase
	end

	// saturating Q32.32 subtract
	assign diff    = {acc_q[ACC_W-1], acc_q} - {prod_s2[ACC_W-1], prod_s2};
	assign acc_sub = (diff[ACC_W] != diff[ACC_W-1]) ?
		(diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
		diff[ACC_W-1:0];

	always_comb begin
		case (phase_q)
			PH_FACT: init_val = to_q32(m_rdata_q);
			PH_FWD:  init_val = to_q32(v_rdata_q);
			default: init_val = to_q32(x_rdata_q);
		endcase
	end

	assign b_val    = (phase_q == PH_FACT) ? m_rdata_q : x_rdata_q;
	assign not_pd   = $signed(acc_q) <= $signed({17'd0, min_pivot_q, 16'h0000});
	assign sqrt_sat = sqrt_root[WORD_W-1] ? WORD_MAX : sqrt_root;

	// next entry of the sequence
	always_comb begin
		nxt_phase = phase_q;
		nxt_i     = i_q;
		nxt_j     = j_q;
		case (phase_q)
			PH_FACT: begin
				if (j_q != i_q) begin
					nxt_j = j_q + 4'd1;
				end else if (!last_i) begin
					nxt_i = i_q + 4'd1;
					nxt_j = '0;
				end else begin
					nxt_phase = PH_FWD;
					nxt_i     = '0;
				end
			end
			PH_FWD: begin
				if (!last_i) begin
					nxt_i = i_q + 4'd1;
				end else begin
					nxt_phase = PH_BWD;
					nxt_i     = IDX_W'(n_q - (IDX_W+1)'(1));
				end
			end
			PH_BWD: begin
				if (i_q != '0) begin
					nxt_i = i_q - 4'd1;
				end else begin
					nxt_phase = PH_EMIT;
					nxt_i     = '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		adv        = 1'b0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		m_raddr    = {i_q, j_q};
		v_raddr    = i_q;
		x_raddr    = i_q;
		m_we       = 1'b0;
		m_waddr    = {row, col};
		m_wdata    = data_word;
		v_we       = 1'b0;
		x_we       = 1'b0;
		x_waddr    = i_q;
		x_wdata    = div_quot;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_WRITE_MATRIX: m_we = (col <= row);
						REQ_WRITE_RHS:    v_we = 1'b1;
						REQ_SOLVE:        state_d = ST_INIT_RD;
						default: ;
					endcase
				end
			end
			ST_INIT_RD: state_d = ST_INIT_CAP;
			ST_INIT_CAP: state_d = (start5 == end5) ? ST_FIN : ST_A_RD;
			ST_A_RD: begin
				m_raddr = (phase_q == PH_BWD) ? {k_q, i_q} : {i_q, k_q};
				state_d = ST_B_RD;
			end
			ST_B_RD: begin
				m_raddr = {j_q, k_q};
				x_raddr = k_q;
				state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				state_d = (({1'b0, k_q} + (IDX_W+1)'(1)) == end5) ? ST_FIN : ST_A_RD;
			end
			ST_FIN: begin
				if (phase_q == PH_FACT && i_q == j_q) begin
					if (not_pd) begin
						state_d = ST_FAIL;
					end else begin
						sqrt_start = 1'b1;
						state_d    = ST_SQRT;
					end
				end else begin
					state_d = ST_PIV_RD;
				end
			end
			ST_PIV_RD: begin
				m_raddr = (phase_q == PH_FACT) ? {j_q, j_q} : {i_q, i_q};
				state_d = ST_PIV_CAP;
			end
			ST_PIV_CAP: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					m_we    = 1'b1;
					m_waddr = {i_q, i_q};
					m_wdata = sqrt_sat;
					adv     = 1'b1;
					state_d = (nxt_phase == PH_EMIT) ? ST_EMIT_RD : ST_INIT_RD;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (phase_q == PH_FACT) begin
						m_we    = 1'b1;
						m_waddr = {i_q, j_q};
						m_wdata = div_quot;
					end else begin
						x_we = 1'b1;
					end
					adv     = 1'b1;
					state_d = (nxt_phase == PH_EMIT) ? ST_EMIT_RD : ST_INIT_RD;
				end
			end
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT: state_d = last_i ? ST_IDLE : ST_EMIT_RD;
			ST_FAIL: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_FACT;
			size_q      <= 5'd16;
			min_pivot_q <= '0;
			emit_q      <= 1'b0;
			fail_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			emit_q  <= (state_q == ST_EMIT);
			fail_q  <= (state_q == ST_FAIL);
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SIZE_IN_USE: size_q      <= cfg_data[4:0];
					CFG_MIN_PIVOT:   min_pivot_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && accept && req_type == REQ_SOLVE)
				phase_q <= PH_FACT;
			else if (adv)
				phase_q <= nxt_phase;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && req_type == REQ_SOLVE) begin
			n_q <= n_init;
			i_q <= '0;
			j_q <= '0;
		end else if (adv) begin
			i_q <= nxt_i;
			j_q <= nxt_j;
		end else if (state_q == ST_EMIT && !last_i) begin
			i_q <= i_q + 4'd1;
		end
		case (state_q)
			ST_INIT_RD:  k_q <= start5[IDX_W-1:0];
			ST_INIT_CAP: acc_q <= init_val;
			ST_B_RD:     a_q <= m_rdata_q;
			ST_MUL:      prod_s2 <= ACC_W'($signed(a_q) * $signed(b_val));
			ST_ACC: begin
				acc_q <= acc_sub;
				k_q   <= k_q + 4'd1;
			end
			default: ;
		endcase
		if (state_q == ST_EMIT) begin
			solution_index <= i_q;
			solution_value <= x_rdata_q;
			status         <= STATUS_OK;
			last           <= last_i;
		end else if (state_q == ST_FAIL) begin
			solution_index <= '0;
			solution_value <= '0;
			status         <= STATUS_FAIL;
			last           <= 1'b1;
		end
	end

	assign result_valid = emit_q || fail_q;

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (m_we)
			mat_mem[m_waddr] <= m_wdata;
		m_rdata_q <= mat_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (v_we)
			vec_mem[row] <= data_word;
		v_rdata_q <= vec_mem[v_raddr];
	end

	always_ff @(posedge clk) begin
		if (x_we)
			x_mem[x_waddr] <= x_wdata;
		x_rdata_q <= x_mem[x_raddr];
	end

	chol_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// the pivot read issued in ST_PIV_RD is on m_rdata_q while div_start is high
	chol_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (m_rdata_q),
		.done     (div_done),
		.quotient (div_quot)
	);

`ifndef NO_ASSERTIONS
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("final result while still busy");
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status) |-> last)
		else $error("failure result not flagged last");
	a_sqrt_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> (phase_q == PH_FACT && i_q == j_q))
		else $error("square root outside a diagonal entry");
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |=> (result_valid && !status))
		else $error("emitted element not presented");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> !(m_we && !sqrt_done && !div_done))
		else $error("matrix write during solve outside a result step");
`endif

endmodule
`default_nettype wire
